### rtl/core/ptte_pkg.sv
// Shared types and constants for the periodic task and timer tick engine.
// No dependencies.
`default_nettype none

package ptte_pkg;

    localparam int unsigned MAX_SLOTS_DEF       = 32;
    localparam int unsigned MAX_DOWN_TIMERS_DEF = 32;
    localparam int unsigned TIME_W              = 32;
    localparam int unsigned CFG_W               = 16;
    localparam int unsigned CFG_IDX_W           = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TASKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMERS = 2'd2;

    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_CFG_TASK     = 4'd1,
        OP_START_TASK   = 4'd2,
        OP_STOP_TASK    = 4'd3,
        OP_SET_PERIOD   = 4'd4,
        OP_CFG_TIMER    = 4'd5,
        OP_START_TIMER  = 4'd6,
        OP_STOP_TIMER   = 4'd7,
        OP_RELOAD_TIMER = 4'd8,
        OP_READ_TIMER   = 4'd9
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;      // capture input transaction
        logic       single;     // apply single-entry operation
        logic       timer_step; // process timer at walk index
        logic       task_step;  // process task at walk index
        logic       walk_clr;   // reset walk index
        logic       walk_inc;   // advance walk index
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       is_tick;
        logic       timer_last; // walk index at or past timer limit
        logic       task_last;  // walk index at or past task limit
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/periodic_task_and_timer_tick_engine_unit.sv
// Top level of the periodic task and timer tick engine.
// Depends on ptte_pkg, ptte_ctrl and ptte_dp.
//
// Keeps periodic task slots and one-shot down-timers. One input transaction
// carries one operation and yields exactly one result. A tick walks every
// active timer, then every active task, one entry per cycle through a single
// shared update path. It passes through ST_DECODE, ST_TIMERS, ST_TASKS and
// ST_DONE; its result turns valid as the engine returns to ST_IDLE, where the
// next transaction can be accepted. Other operations are applied in ST_DECODE
// and then pass through ST_DONE. One transaction is worked at a time; the
// result sits in an output register while the next transaction is taken, and
// a stalled result holds the engine only when the next result is ready.
`default_nettype none

module periodic_task_and_timer_tick_engine_unit
    import ptte_pkg::*;
#(
    parameter int unsigned MAX_SLOTS       = MAX_SLOTS_DEF,
    parameter int unsigned MAX_DOWN_TIMERS = MAX_DOWN_TIMERS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [3:0]           operation,
    input  wire logic [4:0]           slot_index,
    input  wire logic [TIME_W-1:0]    time_value,
    input  wire logic                 enable_flag,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      status,
    output logic [31:0]               task_fire_mask,
    output logic [31:0]               timer_expire_mask,
    output logic [TIME_W-1:0]         timer_reading
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     out_valid_i;

    ptte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid_i),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Load the output register whenever it is empty or being taken
    logic              st_q;
    logic [31:0]       fm_q, em_q;
    logic [TIME_W-1:0] rd_q;
    logic              load_cmd;

    assign load_cmd  = !out_valid_i || !out_stall;
    assign out_valid = out_valid_i;

    ptte_dp #(
        .MAX_SLOTS       (MAX_SLOTS),
        .MAX_DOWN_TIMERS (MAX_DOWN_TIMERS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .operation         (operation),
        .slot_index        (slot_index),
        .time_value        (time_value),
        .enable_flag       (enable_flag),
        .cmd               (cmd),
        .out_load          (load_cmd),
        .stat              (stat),
        .status            (st_q),
        .task_fire_mask    (fm_q),
        .timer_expire_mask (em_q),
        .timer_reading     (rd_q)
    );

    // Present held result
    assign status            = st_q;
    assign task_fire_mask    = fm_q;
    assign timer_expire_mask = em_q;
    assign timer_reading     = rd_q;

endmodule

`default_nettype wire

### rtl/core/ptte_ctrl.sv
// Tick sequencer: takes a transaction, applies it or walks timers then tasks.
// Depends on ptte_pkg.
`default_nettype none

module ptte_ctrl
    import ptte_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TIMERS,
        ST_TASKS,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.walk_clr = 1'b1;
                if (stat.is_tick)
                begin
                    state_next = ST_TIMERS;
                end
                else
                begin
                    cmd.single = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_TIMERS:
            begin
                if (stat.timer_last)
                begin
                    cmd.walk_clr = 1'b1;
                    state_next   = ST_TASKS;
                end
                else
                begin
                    cmd.timer_step = 1'b1;
                    cmd.walk_inc   = 1'b1;
                end
            end
            ST_TASKS:
            begin
                if (stat.task_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.task_step = 1'b1;
                    cmd.walk_inc  = 1'b1;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ptte_dp.sv
// Datapath of the tick engine: entry storage, config registers, result register.
// Depends on ptte_pkg.
`default_nettype none

module ptte_dp
    import ptte_pkg::*;
#(
    parameter int unsigned MAX_SLOTS       = MAX_SLOTS_DEF,
    parameter int unsigned MAX_DOWN_TIMERS = MAX_DOWN_TIMERS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic [3:0]        operation,
    input  wire logic [4:0]        slot_index,
    input  wire logic [TIME_W-1:0] time_value,
    input  wire logic              enable_flag,
    input  wire dp_cmd_t           cmd,
    input  wire logic              out_load,
    output dp_stat_t               stat,
    output logic                   status,
    output logic [31:0]            task_fire_mask,
    output logic [31:0]            timer_expire_mask,
    output logic [TIME_W-1:0]      timer_reading
);

    localparam int unsigned NS = MAX_SLOTS;
    localparam int unsigned NT = MAX_DOWN_TIMERS;

    // Config registers
    logic [15:0] tick_step_reg;
    logic [5:0]  active_tasks_reg;
    logic [5:0]  active_timers_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg     <= 16'd1;
            active_tasks_reg  <= 6'd0;
            active_timers_reg <= 6'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TICK_STEP:     tick_step_reg     <= cfg_data;
                CFG_ACTIVE_TASKS:  active_tasks_reg  <= cfg_data[5:0];
                CFG_ACTIVE_TIMERS: active_timers_reg <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    // Clamp active counts to the parameter limits
    logic [5:0] task_lim, timer_lim;
    assign task_lim  = (active_tasks_reg  > 6'(NS)) ? 6'(NS) : active_tasks_reg;
    assign timer_lim = (active_timers_reg > 6'(NT)) ? 6'(NT) : active_timers_reg;

    // Latched transaction
    logic [3:0]        op_reg;
    logic [4:0]        idx_reg;
    logic [TIME_W-1:0] tv_reg;
    logic              en_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= operation;
            idx_reg <= slot_index;
            tv_reg  <= time_value;
            en_reg  <= enable_flag;
        end
    end

    // Walk index
    logic [5:0] walk_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0;
        end
        else if (cmd.walk_clr)
        begin
            walk_reg <= '0;
        end
        else if (cmd.walk_inc)
        begin
            walk_reg <= walk_reg + 6'd1;
        end
    end

    assign stat.is_tick    = (op_reg == OP_TICK);
    assign stat.timer_last = (walk_reg >= timer_lim);
    assign stat.task_last  = (walk_reg >= task_lim);

    // Entry storage
    logic [TIME_W-1:0] elapsed_reg   [NS];
    logic [TIME_W-1:0] period_reg    [NS];
    logic [TIME_W-1:0] remaining_reg [NT];
    logic [TIME_W-1:0] timeout_reg   [NT];
    logic [NS-1:0]     task_en_reg;
    logic [NT-1:0]     running_reg;

    logic task_ok, timer_ok;
    assign task_ok  = ({1'b0, idx_reg} < task_lim);
    assign timer_ok = ({1'b0, idx_reg} < timer_lim);

    // Walk-index entry operands
    logic [TIME_W-1:0] rem_sel, rem_dec, el_sel, per_sel, el_base;
    logic [TIME_W:0]   el_sum;
    logic              t_fire;
    logic [4:0]        wi;
    assign wi      = walk_reg[4:0];
    assign rem_sel = remaining_reg[wi];
    assign rem_dec = rem_sel - {16'd0, tick_step_reg};
    assign el_sel  = elapsed_reg[wi];
    assign per_sel = period_reg[wi];
    assign t_fire  = task_en_reg[wi] && (el_sel >= per_sel);
    assign el_base = t_fire ? '0 : el_sel;
    assign el_sum  = {1'b0, el_base} + {17'd0, tick_step_reg};

    // Result accumulators
    logic              status_reg;
    logic [31:0]       fire_reg, expire_reg;
    logic [TIME_W-1:0] reading_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            status_reg  <= 1'b0;
            fire_reg    <= '0;
            expire_reg  <= '0;
            reading_reg <= '0;
        end
        if (cmd.single)
        begin
            case (op_reg)
                OP_CFG_TASK, OP_START_TASK, OP_STOP_TASK, OP_SET_PERIOD:
                    status_reg <= !task_ok;
                OP_CFG_TIMER, OP_START_TIMER, OP_STOP_TIMER, OP_RELOAD_TIMER,
                OP_READ_TIMER:
                    status_reg <= !timer_ok;
                default:
                    status_reg <= 1'b0;
            endcase
            if (op_reg == OP_READ_TIMER && timer_ok)
            begin
                reading_reg <= remaining_reg[idx_reg];
            end
        end
        if (cmd.timer_step && running_reg[wi] && rem_dec == '0)
        begin
            expire_reg[wi] <= 1'b1;
        end
        if (cmd.task_step && t_fire)
        begin
            fire_reg[wi] <= 1'b1;
        end
    end

    // Update entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_en_reg <= '0;
            running_reg <= '0;
            for (int i = 0; i < NS; i++)
            begin
                elapsed_reg[i] <= '0;
                period_reg[i]  <= '0;
            end
            for (int i = 0; i < NT; i++)
            begin
                remaining_reg[i] <= '0;
                timeout_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.timer_step && running_reg[wi])
            begin
                remaining_reg[wi] <= rem_dec;
                if (rem_dec == '0)
                begin
                    running_reg[wi] <= 1'b0;
                end
            end
            if (cmd.task_step)
            begin
                elapsed_reg[wi] <= el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
            end
            if (cmd.single && task_ok)
            begin
                case (op_reg)
                    OP_CFG_TASK:
                    begin
                        period_reg[idx_reg]  <= tv_reg;
                        elapsed_reg[idx_reg] <= '0;
                        task_en_reg[idx_reg] <= en_reg;
                    end
                    OP_START_TASK: task_en_reg[idx_reg] <= 1'b1;
                    OP_STOP_TASK:  task_en_reg[idx_reg] <= 1'b0;
                    OP_SET_PERIOD:
                    begin
                        period_reg[idx_reg]  <= tv_reg;
                        elapsed_reg[idx_reg] <= tv_reg;
                    end
                    default: ;
                endcase
            end
            if (cmd.single && timer_ok)
            begin
                case (op_reg)
                    OP_CFG_TIMER:
                    begin
                        timeout_reg[idx_reg]   <= tv_reg;
                        remaining_reg[idx_reg] <= '0;
                        running_reg[idx_reg]   <= en_reg;
                    end
                    OP_START_TIMER:
                    begin
                        remaining_reg[idx_reg] <= timeout_reg[idx_reg];
                        running_reg[idx_reg]   <= 1'b1;
                    end
                    OP_STOP_TIMER: running_reg[idx_reg] <= 1'b0;
                    OP_RELOAD_TIMER:
                    begin
                        timeout_reg[idx_reg] <= tv_reg;
                        if (running_reg[idx_reg])
                        begin
                            remaining_reg[idx_reg] <= tv_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status            <= status_reg;
            task_fire_mask    <= fire_reg;
            timer_expire_mask <= expire_reg;
            timer_reading     <= reading_reg;
        end
    end

endmodule

`default_nettype wire

### test/periodic_task_and_timer_tick_engine_unit_tb.sv
// Testbench for the periodic task and timer tick engine: drives operation
// transactions and register writes, and checks every result against a
// predictor of the task slots and down-timers. Depends on ptte_pkg and the RTL.
`default_nettype none

module periodic_task_and_timer_tick_engine_unit_tb;
    import ptte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        status;
        logic [31:0] fire;
        logic [31:0] expire;
        logic [31:0] reading;
    } tick_result_t;

    // Scheduler predictor with a queue of pending results
    class sched_scoreboard;
        logic [15:0] step;
        logic [5:0]  n_tasks;
        logic [5:0]  n_timers;
        logic [31:0] elapsed [32];
        logic [31:0] period [32];
        logic [31:0] remaining [32];
        logic [31:0] timeout [32];
        logic [31:0] task_on;
        logic [31:0] timer_on;
        tick_result_t pending[$];
        int errors;

        function new();
            step = 1;
            n_tasks = 0;
            n_timers = 0;
            task_on = 0;
            timer_on = 0;
            errors = 0;
            for (int i = 0; i < 32; i++)
            begin
                elapsed[i] = 0;
                period[i] = 0;
                remaining[i] = 0;
                timeout[i] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_TICK_STEP)
                step = val;
            else if (idx == CFG_ACTIVE_TASKS)
                n_tasks = val[5:0];
            else if (idx == CFG_ACTIVE_TIMERS)
                n_timers = val[5:0];
        endfunction

        // Compute the result of one accepted transaction and queue it
        function void note_input(logic [3:0] op, logic [4:0] idx, logic [31:0] tv, logic en);
            tick_result_t r;
            int task_lim;
            int timer_lim;
            logic task_ok;
            logic timer_ok;
            task_lim = (n_tasks > 32) ? 32 : n_tasks;
            timer_lim = (n_timers > 32) ? 32 : n_timers;
            task_ok = idx < task_lim;
            timer_ok = idx < timer_lim;
            r = '{1'b0, 32'd0, 32'd0, 32'd0};
            case (op)
                OP_TICK:
                begin
                    for (int i = 0; i < timer_lim; i++)
                        if (timer_on[i])
                        begin
                            remaining[i] = remaining[i] - step;
                            if (remaining[i] == 0)
                            begin
                                timer_on[i] = 1'b0;
                                r.expire[i] = 1'b1;
                            end
                        end
                    for (int i = 0; i < task_lim; i++)
                    begin
                        if (task_on[i] && elapsed[i] >= period[i])
                        begin
                            elapsed[i] = 0;
                            r.fire[i] = 1'b1;
                        end
                        if ({1'b0, elapsed[i]} + step > 33'hFFFFFFFF)
                            elapsed[i] = 32'hFFFFFFFF;
                        else
                            elapsed[i] = elapsed[i] + step;
                    end
                end
                OP_CFG_TASK, OP_START_TASK, OP_STOP_TASK, OP_SET_PERIOD:
                begin
                    if (!task_ok)
                        r.status = 1'b1;
                    else if (op == OP_CFG_TASK)
                    begin
                        period[idx] = tv;
                        elapsed[idx] = 0;
                        task_on[idx] = en;
                    end
                    else if (op == OP_START_TASK)
                        task_on[idx] = 1'b1;
                    else if (op == OP_STOP_TASK)
                        task_on[idx] = 1'b0;
                    else
                    begin
                        period[idx] = tv;
                        elapsed[idx] = tv;
                    end
                end
                OP_CFG_TIMER, OP_START_TIMER, OP_STOP_TIMER, OP_RELOAD_TIMER,
                OP_READ_TIMER:
                begin
                    if (!timer_ok)
                        r.status = 1'b1;
                    else if (op == OP_CFG_TIMER)
                    begin
                        timeout[idx] = tv;
                        remaining[idx] = 0;
                        timer_on[idx] = en;
                    end
                    else if (op == OP_START_TIMER)
                    begin
                        remaining[idx] = timeout[idx];
                        timer_on[idx] = 1'b1;
                    end
                    else if (op == OP_STOP_TIMER)
                        timer_on[idx] = 1'b0;
                    else if (op == OP_RELOAD_TIMER)
                    begin
                        timeout[idx] = tv;
                        if (timer_on[idx])
                            remaining[idx] = tv;
                    end
                    else
                        r.reading = remaining[idx];
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(tick_result_t got);
            tick_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.fire !== want.fire)
            begin
                $error("task_fire_mask: expected %h, got %h", want.fire, got.fire);
                errors++;
            end
            if (got.expire !== want.expire)
            begin
                $error("timer_expire_mask: expected %h, got %h", want.expire, got.expire);
                errors++;
            end
            if (got.reading !== want.reading)
            begin
                $error("timer_reading: expected %h, got %h", want.reading, got.reading);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  operation;
    logic [4:0]  slot_index;
    logic [31:0] time_value;
    logic        enable_flag;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [31:0] task_fire_mask;
    logic [31:0] timer_expire_mask;
    logic [31:0] timer_reading;

    sched_scoreboard sb;
    int idle_cycles;
    int burst_left;

    periodic_task_and_timer_tick_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .slot_index(slot_index),
        .time_value(time_value), .enable_flag(enable_flag),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .task_fire_mask(task_fire_mask),
        .timer_expire_mask(timer_expire_mask), .timer_reading(timer_reading)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver stall pattern: phases of none, light and heavy stalling
    always @(posedge clk)
    begin
        int mode;
        mode = int'(($time / 20000) % 3);
        if (mode == 0)
            out_stall <= 1'b0;
        else if (mode == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= ($urandom_range(0, 3) != 0);
    end

    // Check accepted results and count cycles with no transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result('{status, task_fire_mask, timer_expire_mask, timer_reading});
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL periodic_task_and_timer_tick_engine_unit");
                $finish;
            end
        end
    end

    // Send one transaction, with burst gaps before it
    task automatic send_op(logic [3:0] op, logic [4:0] idx, logic [31:0] tv, logic en);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        slot_index <= idx;
        time_value <= tv;
        enable_flag <= en;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(op, idx, tv, en);
    endtask

    // Let all results drain, then write a register while idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 8);
            1: return $urandom_range(0, 64);
            2: return 32'hFFFFFFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Random phase with mostly small indexes and a mix of small, near-maximum and random time values
    task automatic random_phase(int count);
        logic [3:0] op;
        logic [4:0] idx;
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                op = OP_TICK;
            else if (r < 97)
                op = 4'($urandom_range(1, 9));
            else
                op = 4'($urandom_range(10, 15));
            idx = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
            send_op(op, idx, rand_time(), 1'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = '0;
        slot_index = '0;
        time_value = '0;
        enable_flag = 1'b0;
        out_stall = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: nothing active, every index out of range
        send_op(OP_CFG_TASK, 0, 5, 1);
        send_op(OP_READ_TIMER, 0, 0, 0);
        send_op(OP_TICK, 0, 0, 0);
        write_reg(CFG_ACTIVE_TASKS, 32);
        write_reg(CFG_ACTIVE_TIMERS, 32);
        // Directed: extremes, every operation and zero-count running timer
        send_op(OP_CFG_TASK, 31, 32'hFFFFFFFF, 1);
        send_op(OP_CFG_TASK, 0, 0, 1);
        send_op(OP_SET_PERIOD, 1, 2, 0);
        send_op(OP_START_TASK, 1, 0, 0);
        send_op(OP_CFG_TIMER, 31, 1, 1);
        send_op(OP_CFG_TIMER, 0, 2, 0);
        send_op(OP_START_TIMER, 0, 0, 0);
        send_op(OP_TICK, 0, 0, 0);
        send_op(OP_READ_TIMER, 31, 0, 0);
        send_op(OP_TICK, 0, 0, 0);
        send_op(OP_RELOAD_TIMER, 31, 32'hAAAA5555, 0);
        send_op(OP_STOP_TIMER, 0, 0, 0);
        send_op(OP_STOP_TASK, 31, 0, 0);
        send_op(OP_READ_TIMER, 31, 0, 0);
        send_op(4'd15, 31, 32'hFFFFFFFF, 1);
        send_op(4'd10, 0, 0, 0);
        write_reg(CFG_TICK_STEP, 0);
        send_op(OP_TICK, 0, 0, 0);
        write_reg(CFG_TICK_STEP, 16'hFFFF);
        send_op(OP_TICK, 0, 0, 0);
        send_op(OP_TICK, 0, 0, 0);
        // Active counts above the limit
        write_reg(CFG_ACTIVE_TASKS, 63);
        write_reg(CFG_ACTIVE_TIMERS, 40);
        send_op(OP_TICK, 0, 0, 0);

        // Random phases across register settings
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_TICK_STEP, (ph % 4 == 0) ? 16'hFFFF : 16'($urandom_range(0, 4)));
            write_reg(CFG_ACTIVE_TASKS, (ph == 3) ? 16'd0 : 16'($urandom_range(1, 34)));
            write_reg(CFG_ACTIVE_TIMERS, (ph == 5) ? 16'd0 : 16'($urandom_range(1, 34)));
            random_phase(100);
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS periodic_task_and_timer_tick_engine_unit");
        else
            $display("FAIL periodic_task_and_timer_tick_engine_unit");
        $finish;
    end
endmodule

`default_nettype wire

### filelist.f
rtl/core/ptte_pkg.sv
rtl/core/ptte_ctrl.sv
rtl/core/ptte_dp.sv
rtl/core/periodic_task_and_timer_tick_engine_unit.sv
test/periodic_task_and_timer_tick_engine_unit_tb.sv
